// ----- hdl/cmee_pkg.sv -----
// Shared constants, types and helpers for the MIDI control/note event emitter.
// Used by cmee_core and control_to_midi_event_emitter_unit; no dependencies.
`default_nettype none

package cmee_pkg;

    localparam int LIVE_SIGNALS_DEF  = 32;
    localparam int GESTURE_SLOTS_DEF = 8;

    // Widths fixed by the item fields
    localparam int INDEX_W = 5;
    localparam int LEVEL_W = 16;
    localparam int NOTE_W  = 7;
    localparam int VAL_W   = 7;
    localparam int BYTE_W  = 8;

    // Q1.15 constants
    localparam logic [LEVEL_W-1:0] ONE_Q15       = 16'd32768;
    localparam logic [LEVEL_W-1:0] THR_MIN_Q15   = 16'd1638;
    localparam logic [LEVEL_W-1:0] HYST_Q15      = 16'd2294;
    localparam logic [LEVEL_W-1:0] OFF_FLOOR_Q15 = 16'd655;

    localparam logic [6:0] CC_BASE_MAX = 7'd119;

    // MIDI status nibbles
    localparam logic [BYTE_W-1:0] ST_CC       = 8'hB0;
    localparam logic [BYTE_W-1:0] ST_NOTE_ON  = 8'h90;
    localparam logic [BYTE_W-1:0] ST_NOTE_OFF = 8'h80;

    // Item kinds carried in tuser
    localparam logic ACT_LIVE    = 1'b0;
    localparam logic ACT_GESTURE = 1'b1;

    // Configuration register indexes
    localparam logic [7:0] REG_SEND_CC      = 8'd0;
    localparam logic [7:0] REG_SEND_NOTES   = 8'd1;
    localparam logic [7:0] REG_CC_BASE      = 8'd2;
    localparam logic [7:0] REG_MIDI_CHANNEL = 8'd3;

    typedef struct packed {
        logic       send_cc;
        logic       send_notes;
        logic [6:0] cc_base;
        logic [4:0] midi_channel;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] status_byte;
        logic [BYTE_W-1:0] data_one;
        logic [VAL_W-1:0]  data_two;
    } event_t;

    // round(level * 127 / 32768), half up; level already saturated to 1.0
    function automatic logic [VAL_W-1:0] to_7bit(input logic [LEVEL_W-1:0] lvl);
        logic [22:0] prod;
        prod = {7'd0, lvl} * 23'd127 + 23'd16384;
        return prod[21:15];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/cmee_core.sv -----
// Per-item decision logic and per-index state (last CC value, note gates).
// Depends on cmee_pkg.
`default_nettype none

module cmee_core #(
    parameter int LIVE_SIGNALS  = cmee_pkg::LIVE_SIGNALS_DEF,
    parameter int GESTURE_SLOTS = cmee_pkg::GESTURE_SLOTS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         item_accept,
    input  wire logic                         action,
    input  wire logic [cmee_pkg::INDEX_W-1:0] index,
    input  wire logic [cmee_pkg::LEVEL_W-1:0] level,
    input  wire logic [cmee_pkg::LEVEL_W-1:0] gate_threshold,
    input  wire logic [cmee_pkg::NOTE_W-1:0]  note_number,
    input  wire cmee_pkg::cfg_t               cfg,
    output cmee_pkg::event_t                  evt
);

    // Only indexes the 5-bit field can reach need storage
    localparam int IDX_SPAN   = 1 << cmee_pkg::INDEX_W;
    localparam int LIVE_DEPTH = (LIVE_SIGNALS < IDX_SPAN) ? LIVE_SIGNALS : IDX_SPAN;
    localparam int SLOT_DEPTH = (GESTURE_SLOTS < IDX_SPAN) ? GESTURE_SLOTS : IDX_SPAN;
    localparam int LIVE_AW    = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
    localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

    logic [cmee_pkg::BYTE_W-1:0] last_sent_reg [LIVE_DEPTH];
    logic                        note_active_reg [SLOT_DEPTH];
    logic [cmee_pkg::NOTE_W-1:0] latched_note_reg [SLOT_DEPTH];

    logic [cmee_pkg::LEVEL_W-1:0] level_sat;
    logic [cmee_pkg::LEVEL_W-1:0] thr_sat;
    logic [cmee_pkg::LEVEL_W-1:0] off_lvl;
    logic [cmee_pkg::VAL_W-1:0]   v7;
    logic [cmee_pkg::VAL_W-1:0]   vel;
    logic [3:0]                   ch;
    logic [6:0]                   base;
    logic [LIVE_AW-1:0]           live_addr;
    logic [SLOT_AW-1:0]           slot_addr;
    logic                         live_ok;
    logic                         slot_ok;
    logic                         cc_fire;
    logic                         gate_on;
    logic                         gate_want;
    logic                         gate_fire;

    always_comb begin
        level_sat = (level > cmee_pkg::ONE_Q15) ? cmee_pkg::ONE_Q15 : level;
        v7        = cmee_pkg::to_7bit(level_sat);
        vel       = (v7 == '0) ? cmee_pkg::VAL_W'(1) : v7;

        if (cfg.midi_channel == 5'd0) begin
            ch = 4'd0;
        end else if (cfg.midi_channel > 5'd16) begin
            ch = 4'd15;
        end else begin
            ch = 4'(cfg.midi_channel - 5'd1);
        end
        base = (cfg.cc_base > cmee_pkg::CC_BASE_MAX) ? cmee_pkg::CC_BASE_MAX : cfg.cc_base;

        live_addr = index[LIVE_AW-1:0];
        slot_addr = index[SLOT_AW-1:0];
        live_ok   = 32'(index) < LIVE_SIGNALS;
        slot_ok   = 32'(index) < GESTURE_SLOTS;

        cc_fire = (action == cmee_pkg::ACT_LIVE) && live_ok && cfg.send_cc
                  && ({1'b0, v7} != last_sent_reg[live_addr]);

        if (gate_threshold < cmee_pkg::THR_MIN_Q15) begin
            thr_sat = cmee_pkg::THR_MIN_Q15;
        end else if (gate_threshold > cmee_pkg::ONE_Q15) begin
            thr_sat = cmee_pkg::ONE_Q15;
        end else begin
            thr_sat = gate_threshold;
        end
        // hysteresis floor: max(0.02, thr - 0.07)
        if (thr_sat < cmee_pkg::HYST_Q15 + cmee_pkg::OFF_FLOOR_Q15) begin
            off_lvl = cmee_pkg::OFF_FLOOR_Q15;
        end else begin
            off_lvl = thr_sat - cmee_pkg::HYST_Q15;
        end

        gate_on   = note_active_reg[slot_addr];
        gate_want = cfg.send_notes && (gate_on ? (level_sat > off_lvl) : (level_sat > thr_sat));
        gate_fire = (action == cmee_pkg::ACT_GESTURE) && slot_ok && (gate_want != gate_on);

        evt = '0;
        if (cc_fire) begin
            evt.valid       = 1'b1;
            evt.status_byte = cmee_pkg::ST_CC | {4'd0, ch};
            evt.data_one    = 8'(base) + 8'(index);
            evt.data_two    = v7;
        end else if (gate_fire) begin
            evt.valid = 1'b1;
            if (gate_want) begin
                evt.status_byte = cmee_pkg::ST_NOTE_ON | {4'd0, ch};
                evt.data_one    = {1'b0, note_number};
                evt.data_two    = vel;
            end else begin
                evt.status_byte = cmee_pkg::ST_NOTE_OFF | {4'd0, ch};
                evt.data_one    = {1'b0, latched_note_reg[slot_addr]};
                evt.data_two    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LIVE_DEPTH; i++) begin
                last_sent_reg[i] <= '1;
            end
            for (int i = 0; i < SLOT_DEPTH; i++) begin
                note_active_reg[i] <= 1'b0;
            end
        end else if (item_accept) begin
            if (cc_fire) begin
                last_sent_reg[live_addr] <= {1'b0, v7};
            end
            if (gate_fire) begin
                note_active_reg[slot_addr] <= gate_want;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_DEPTH; i++) begin
                latched_note_reg[i] <= '0;
            end
        end else if (item_accept && gate_fire && gate_want) begin
            latched_note_reg[slot_addr] <= note_number;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/control_to_midi_event_emitter_unit.sv -----
// Top level of the MIDI control/note event emitter: config registers,
// stream handshake and result register. Depends on cmee_pkg and cmee_core.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_tvalid / s_tready  | s_tdata, s_tuser (action)
//  m_      | out       | m_tvalid / m_tready  | m_tdata
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle while s_tready is high: the item is decided, the
// per-index state updated and the event captured in the result register at
// the accept edge. s_tready is low only while a held result is not being taken.
// Reset sets all state but the result data register at once; no clearing pass.
`default_nettype none

module control_to_midi_event_emitter_unit #(
    parameter int LIVE_SIGNALS  = cmee_pkg::LIVE_SIGNALS_DEF,
    parameter int GESTURE_SLOTS = cmee_pkg::GESTURE_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [4:0] index, [20:5] level, [36:21] gate_threshold, [43:37] note_number
    input  wire logic [47:0] s_tdata,
    // [0] action
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] status_byte, [15:8] data_one, [22:16] data_two
    output logic [23:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    cmee_pkg::cfg_t   cfg_reg;
    cmee_pkg::event_t evt;
    logic             item_accept;
    logic             m_valid_reg;
    logic [23:0]      m_data_reg;

    assign s_tready    = !m_valid_reg || m_tready;
    assign item_accept = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.send_cc      <= 1'b1;
            cfg_reg.send_notes   <= 1'b1;
            cfg_reg.cc_base      <= 7'd30;
            cfg_reg.midi_channel <= 5'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cmee_pkg::REG_SEND_CC:      cfg_reg.send_cc      <= cfg_data[0];
                cmee_pkg::REG_SEND_NOTES:   cfg_reg.send_notes   <= cfg_data[0];
                cmee_pkg::REG_CC_BASE:      cfg_reg.cc_base      <= cfg_data[6:0];
                cmee_pkg::REG_MIDI_CHANNEL: cfg_reg.midi_channel <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    cmee_core #(
        .LIVE_SIGNALS  (LIVE_SIGNALS),
        .GESTURE_SLOTS (GESTURE_SLOTS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_accept    (item_accept),
        .action         (s_tuser[0]),
        .index          (s_tdata[4:0]),
        .level          (s_tdata[20:5]),
        .gate_threshold (s_tdata[36:21]),
        .note_number    (s_tdata[43:37]),
        .cfg            (cfg_reg),
        .evt            (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= item_accept && evt.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept && evt.valid) begin
            m_data_reg <= {1'b0, evt.data_two, evt.data_one, evt.status_byte};
        end
    end

endmodule

`default_nettype wire
